/* hdl/residence_time_tracker_core_defines.svh */
// Assertion macros used by the checker file
`ifndef RESIDENCE_TIME_TRACKER_CORE_DEFINES_SVH
`define RESIDENCE_TIME_TRACKER_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define RTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, with the consequent checked in the cycle after the antecedent
`define RTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rtt_pkg.sv */
// Types and constants of the residence time tracker
`timescale 1ns / 1ps
package rtt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam logic [15:0] SERVICE_PORT_RST = 16'd57843;
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic {
    OP_INGRESS = 1'b0,
    OP_EGRESS  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CLS_IGNORE,
    CLS_RECORD,
    CLS_RESOLVE
  } cls_e;

  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_RECORDED = 3'd1,
    ST_FULL     = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_WRITE,
    BK_SUB,
    BK_ADD,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    cls_e        cls;
    logic [63:0] key;
    logic [15:0] port;
    logic [63:0] carried;
    logic [63:0] now;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [15:0] port;
    logic [63:0] arrival;
    logic [15:0] order;
  } entry_t;

endpackage

/* hdl/rtt_front.sv */
// Front end: service port register, event classification and item queue
`timescale 1ns / 1ps
module rtt_front
  import rtt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        opcode_i,
  input  logic        is_udp_i,
  input  logic [31:0] src_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] packet_id_i,
  input  logic [63:0] carried_time_i,
  input  logic [63:0] now_ns_i,
  input  logic        clearing_i,
  output logic        item_valid_o,
  output item_t       item_o,
  input  logic        item_pop_i
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [15:0] service_port_q;
  item_t       fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic        accept, q_full;
  item_t       new_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      service_port_q <= SERVICE_PORT_RST;
    end else if (cfg_valid_i) begin
      service_port_q <= cfg_data_i;
    end
  end

  always_comb begin
    new_item.key     = {src_addr_i, packet_id_i};
    new_item.port    = src_port_i;
    new_item.carried = carried_time_i;
    new_item.now     = now_ns_i;
    if (!is_udp_i || (src_port_i != service_port_q)) begin
      new_item.cls = CLS_IGNORE;
    end else if (op_e'(opcode_i) == OP_INGRESS) begin
      new_item.cls = CLS_RECORD;
    end else begin
      new_item.cls = CLS_RESOLVE;
    end
  end

  assign q_full       = (count_q == CNT_W'(FIFO_DEPTH));
  assign full         = q_full || clearing_i;
  assign accept       = push && !full;
  assign item_valid_o = (count_q != '0);
  assign item_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fifo_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (accept) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (item_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (accept && !item_pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!accept && item_pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* hdl/rtt_back.sv */
// Back end: entry table, scan sequencer, time arithmetic and result register
`timescale 1ns / 1ps
module rtt_back
  import rtt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  output logic        clearing_o,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_pop_o,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [63:0] new_time_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = IDX_W + 1;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_q, wr_data;
  logic   we, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  bk_state_e state_q, state_d;
  item_t     cur_q, cur_d;
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic             rvalid_q, rvalid_d;
  logic [IDX_W-1:0] ridx_q, ridx_d, slot_q, slot_d, best_idx_q, best_idx_d;
  logic             found_q, found_d;
  logic [15:0]      best_age_q, best_age_d, ins_q, ins_d, age;
  logic [63:0]      best_arr_q, best_arr_d, diff_q, diff_d;
  status_e          res_status_q, res_status_d;
  logic [63:0]      res_time_q, res_time_d;
  logic             out_valid_q, out_load, last, matched;
  status_e          out_status_q;
  logic [63:0]      out_time_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign last    = rvalid_q && (ridx_q == IDX_W'(TABLE_ENTRIES - 1));
  assign age     = ins_q - rd_data_q.order;
  assign matched = rd_data_q.valid && (rd_data_q.key == cur_q.key)
                   && (rd_data_q.port == cur_q.port);

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    rd_cnt_d     = rd_cnt_q;
    rvalid_d     = rvalid_q;
    ridx_d       = ridx_q;
    slot_d       = slot_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_age_d   = best_age_q;
    best_arr_d   = best_arr_q;
    diff_d       = diff_q;
    ins_d        = ins_q;
    res_status_d = res_status_q;
    res_time_d   = res_time_q;
    we           = 1'b0;
    wr_addr      = rd_cnt_q[IDX_W-1:0];
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = rd_cnt_q[IDX_W-1:0];
    item_pop_o   = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      BK_CLEAR: begin
        we       = 1'b1;
        rd_cnt_d = rd_cnt_q + 1'b1;
        if (rd_cnt_q[IDX_W-1:0] == IDX_W'(TABLE_ENTRIES - 1)) begin
          rd_cnt_d = '0;
          state_d  = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          cur_d      = item_i;
          rd_cnt_d   = '0;
          rvalid_d   = 1'b0;
          found_d    = 1'b0;
          if (item_i.cls == CLS_IGNORE) begin
            res_status_d = ST_IGNORED;
            res_time_d   = '0;
            state_d      = BK_DONE;
          end else begin
            state_d = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (rd_cnt_q < CNT_W'(TABLE_ENTRIES)) begin
          rd_en    = 1'b1;
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        rvalid_d = rd_en;
        ridx_d   = rd_cnt_q[IDX_W-1:0];
        if (rvalid_q) begin
          if (cur_q.cls == CLS_RECORD) begin
            if (!rd_data_q.valid) begin
              slot_d  = ridx_q;
              state_d = BK_WRITE;
            end else if (last) begin
              res_status_d = ST_FULL;
              res_time_d   = '0;
              state_d      = BK_DONE;
            end
          end else begin
            // strictly greater age wins, so equal ages keep the lower index
            if (matched && (!found_q || (age > best_age_q))) begin
              found_d    = 1'b1;
              best_idx_d = ridx_q;
              best_age_d = age;
              best_arr_d = rd_data_q.arrival;
            end
            if (last) begin
              if (found_d) begin
                state_d = BK_SUB;
              end else begin
                res_status_d = ST_MISS;
                res_time_d   = cur_q.now - cur_q.carried;
                state_d      = BK_DONE;
              end
            end
          end
        end
      end
      BK_WRITE: begin
        we              = 1'b1;
        wr_addr         = slot_q;
        wr_data.valid   = 1'b1;
        wr_data.key     = cur_q.key;
        wr_data.port    = cur_q.port;
        wr_data.arrival = cur_q.now;
        wr_data.order   = ins_q;
        ins_d           = ins_q + 1'b1;
        res_status_d    = ST_RECORDED;
        res_time_d      = '0;
        state_d         = BK_DONE;
      end
      BK_SUB: begin
        we      = 1'b1;
        wr_addr = best_idx_q;
        diff_d  = cur_q.now - best_arr_q;
        state_d = BK_ADD;
      end
      BK_ADD: begin
        res_status_d = ST_HIT;
        res_time_d   = cur_q.carried + diff_q;
        state_d      = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_q) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      rd_cnt_q    <= '0;
      rvalid_q    <= 1'b0;
      found_q     <= 1'b0;
      ins_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      rvalid_q <= rvalid_d;
      found_q  <= found_d;
      ins_q    <= ins_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    ridx_q       <= ridx_d;
    slot_q       <= slot_d;
    best_idx_q   <= best_idx_d;
    best_age_q   <= best_age_d;
    best_arr_q   <= best_arr_d;
    diff_q       <= diff_d;
    res_status_q <= res_status_d;
    res_time_q   <= res_time_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_time_q   <= res_time_q;
    end
  end

  assign clearing_o = (state_q == BK_CLEAR);
  assign empty      = !out_valid_q;
  assign status_o   = out_status_q;
  assign new_time_o = out_time_q;

endmodule

/* hdl/residence_time_tracker_core.sv */
// Top level of the residence time tracker
//
//  channel  | direction | handshake          | beat
//  ---------+-----------+--------------------+-------------------------------------
//  event    | in        | push / full        | opcode, is_udp, addr, port, id, times
//  result   | out       | empty / pop        | status, new_time
//  config   | in        | cfg_valid/cfg_ready| service port
//
// Ignored events skip the table. An ingress event scans the entry table up to
// the first free entry, or all of it when full; an egress event scans all of
// it, then a hit runs a subtract and an add step. The scan makes one read a cycle.
// After reset a clearing pass writes every entry of the table with full high.
// The event queue holds two beats, so events are taken while a result waits.
`timescale 1ns / 1ps
module residence_time_tracker_core
  import rtt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        opcode_i,
  input  logic        is_udp_i,
  input  logic [31:0] src_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] packet_id_i,
  input  logic signed [63:0] carried_time_i,
  input  logic signed [63:0] now_ns_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic signed [63:0] new_time_o
);

  logic  clearing, item_valid, item_pop;
  item_t item;

  rtt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode_i),
    .is_udp_i       (is_udp_i),
    .src_addr_i     (src_addr_i),
    .src_port_i     (src_port_i),
    .packet_id_i    (packet_id_i),
    .carried_time_i (carried_time_i),
    .now_ns_i       (now_ns_i),
    .clearing_i     (clearing),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_pop_i     (item_pop)
  );

  rtt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clearing_o   (clearing),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .empty        (empty),
    .pop          (pop),
    .status_o     (status_o),
    .new_time_o   (new_time_o)
  );

endmodule

/* hdl/rtt_checker.sv */
// Port-level checks of the residence time tracker, bound to the top level
`timescale 1ns / 1ps
`include "residence_time_tracker_core_defines.svh"
module rtt_checker
  import rtt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  status_o,
  input logic [63:0] new_time_o
);

  `RTT_ASSERT(a_status_code, !empty |-> (status_o <= ST_MISS), "status code out of range")
  `RTT_ASSERT(a_zero_time, (!empty && (status_o == ST_IGNORED || status_o == ST_RECORDED || status_o == ST_FULL)) |-> (new_time_o == '0), "non-egress result with nonzero time")
  `RTT_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(status_o) && $stable(new_time_o), "waiting result changed")
  `RTT_ASSERT_NEXT(a_pop_drains, !empty && pop, empty, "result register not freed by pop")

endmodule

bind residence_time_tracker_core rtt_checker u_rtt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .status_o   (status_o),
  .new_time_o (new_time_o)
);
